FILE: hw/rtl/bblur_pkg.sv
package bblur_pkg;

    localparam int CH_W      = 8;
    localparam int PIX_W     = 4 * CH_W;
    localparam int SUM_W     = 12;
    localparam int ROW_W     = 16;
    localparam int OUT_COL_W = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_W_W    = 12;
    localparam int CFG_H_W    = 16;
    localparam int CFG_C_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [CFG_W_W-1:0] WIDTH_RESET   = 12'd640;
    localparam logic [CFG_H_W-1:0] HEIGHT_RESET  = 16'd480;
    localparam logic [CFG_C_W-1:0] CHANNEL_RESET = 3'd3;
    localparam logic [CFG_C_W-1:0] CHAN_ALPHA    = 3'd4;

    localparam int MIN_DIM = 3;

    // floor(s / 9) == (s * 3641) >> 15 for every s below 4096
    localparam logic [SUM_W-1:0] DIV9_MUL   = 12'd3641;
    localparam int               DIV9_SHIFT = 15;

    // Result queue
    localparam int QD    = 4;
    localparam int QCNT_W = 3;
    localparam int QIDX_W = 2;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] column;
        logic [CH_W-1:0]      red;
        logic [CH_W-1:0]      green;
        logic [CH_W-1:0]      blue;
        logic [CH_W-1:0]      alpha;
        logic                 last;
    } result_t;

endpackage

FILE: hw/rtl/bblur_pix_if.sv
interface bblur_pix_if;
    logic                       valid;
    logic                       ready;
    logic [bblur_pkg::CH_W-1:0] red_in;
    logic [bblur_pkg::CH_W-1:0] green_in;
    logic [bblur_pkg::CH_W-1:0] blue_in;
    logic [bblur_pkg::CH_W-1:0] alpha_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output alpha_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input alpha_in, output ready);
endinterface

FILE: hw/rtl/bblur_res_if.sv
interface bblur_res_if;
    logic                            valid;
    logic                            ready;
    logic [bblur_pkg::ROW_W-1:0]     out_row;
    logic [bblur_pkg::OUT_COL_W-1:0] out_column;
    logic [bblur_pkg::CH_W-1:0]      red_out;
    logic [bblur_pkg::CH_W-1:0]      green_out;
    logic [bblur_pkg::CH_W-1:0]      blue_out;
    logic [bblur_pkg::CH_W-1:0]      alpha_out;
    logic                            last_of_run;

    modport source (output valid, output out_row, output out_column, output red_out,
                    output green_out, output blue_out, output alpha_out,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_column, input red_out,
                    input green_out, input blue_out, input alpha_out,
                    input last_of_run, output ready);
endinterface

FILE: hw/rtl/box_blur_3x3_border_copy_unit.sv
// Path: an accepted pixel passes stage A, stage B, then the result queue; a second
//   result from the same pixel is queued behind the first. Throughput: one pixel
//   per cycle while the queue has room. Results drain one per cycle while res.ready
//   is high, from a 4-entry queue; two-result pixels (last column, last row) can fill it.
// Reset (rst_n, async low): clears counters, window and queue; config returns to its
//   defaults. Line stores are not cleared; only current-frame rows reach blur sums.
module box_blur_3x3_border_copy_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]   cfg_data,
    bblur_pix_if.sink                          pix,
    bblur_res_if.source                        res
);

    // Column counter / line store address width, and a compare width that holds
    // both the 12-bit width register and MAX_WIDTH itself.
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > bblur_pkg::CFG_W_W) ? CW + 1 : bblur_pkg::CFG_W_W;

    localparam int PW = bblur_pkg::PIX_W;
    localparam int RW = bblur_pkg::ROW_W;
    localparam int OW = bblur_pkg::OUT_COL_W;
    localparam int SW = bblur_pkg::SUM_W;
    localparam int QN = bblur_pkg::QCNT_W;

    // ------------------------------------------------------------------
    // Configuration registers. Any write restarts the frame.
    // ------------------------------------------------------------------
    logic [bblur_pkg::CFG_W_W-1:0] width_cfg_reg;
    logic [bblur_pkg::CFG_H_W-1:0] height_cfg_reg;
    logic [bblur_pkg::CFG_C_W-1:0] chan_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= bblur_pkg::WIDTH_RESET;
            height_cfg_reg <= bblur_pkg::HEIGHT_RESET;
            chan_cfg_reg   <= bblur_pkg::CHANNEL_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                bblur_pkg::REG_IMAGE_WIDTH:
                    width_cfg_reg <= cfg_data[bblur_pkg::CFG_W_W-1:0];
                bblur_pkg::REG_IMAGE_HEIGHT:
                    height_cfg_reg <= cfg_data[bblur_pkg::CFG_H_W-1:0];
                bblur_pkg::REG_CHANNEL_COUNT:
                    chan_cfg_reg <= cfg_data[bblur_pkg::CFG_C_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Effective frame size: width clamped to 3..MAX_WIDTH, height to at least 3.
    logic [WW-1:0] w_raw;
    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff;

    always_comb
    begin
        w_raw = WW'(width_cfg_reg);
        priority if (w_raw < WW'(bblur_pkg::MIN_DIM))
            w_eff = WW'(bblur_pkg::MIN_DIM);
        else if (w_raw > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = w_raw;
        h_eff = (height_cfg_reg < RW'(bblur_pkg::MIN_DIM)) ? RW'(bblur_pkg::MIN_DIM)
                                                          : height_cfg_reg;
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    //   stage A: accepted pixel + line store read data
    //   stage B: channel sums, result flags
    //   queue  : up to 4 finished results
    // The whole pipe advances when B can drop its results into the queue.
    // ------------------------------------------------------------------
    logic          a_valid_reg;
    logic          b_valid_reg;
    logic          b_blur_reg;
    logic          b_border_reg;
    logic [QN-1:0] cnt_reg;
    logic [1:0]    b_nres;
    logic [QN-1:0] q_free;
    logic          adv;
    logic          pix_acc;
    logic          a_move;
    logic          b_push;
    logic          pop;

    assign b_nres  = {1'b0, b_blur_reg} + {1'b0, b_border_reg};
    assign q_free  = QN'(bblur_pkg::QD) - cnt_reg;
    assign adv     = !b_valid_reg || (QN'(b_nres) <= q_free);
    assign pix.ready = !a_valid_reg || adv;
    assign pix_acc = pix.valid && pix.ready;
    assign a_move  = a_valid_reg && adv;
    assign b_push  = b_valid_reg && adv;
    assign res.valid = (cnt_reg != '0);
    assign pop     = res.valid && res.ready;

    // ------------------------------------------------------------------
    // Raster position counters
    // ------------------------------------------------------------------
    logic [CW-1:0]  col_cnt_reg;
    logic [RW-1:0]  row_cnt_reg;
    logic [WW-1:0]  c_ext;
    logic           col_last;
    logic           row_last;
    logic           border_now;
    logic           blur_now;

    always_comb
    begin
        c_ext      = WW'(col_cnt_reg);
        col_last   = (c_ext + WW'(1)) >= w_eff;
        row_last   = ({1'b0, row_cnt_reg} + (RW+1)'(1)) >= {1'b0, h_eff};
        border_now = (row_cnt_reg == '0) || (row_cnt_reg >= h_eff - RW'(1))
                  || (col_cnt_reg == '0) || (c_ext >= w_eff - WW'(1));
        // A full 3x3 neighborhood closes on this pixel
        blur_now   = (row_cnt_reg >= RW'(2)) && (c_ext >= WW'(2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (pix_acc)
        begin
            if (col_last)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= row_last ? '0 : row_cnt_reg + RW'(1);
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Line stores: one memory, upper half = older row, lower half = newer row.
    // Read at accept, written back when the pixel leaves stage A. Consecutive
    // pixels never share a column, so the pending write never collides.
    // ------------------------------------------------------------------
    logic [2*PW-1:0] line_mem [MAX_WIDTH];
    logic [2*PW-1:0] line_rd_reg;
    logic [CW-1:0]   a_addr_reg;
    logic [PW-1:0]   a_px_reg;
    logic [PW-1:0]   px_in;

    assign px_in = {(chan_cfg_reg == bblur_pkg::CHAN_ALPHA) ? pix.alpha_in
                                                           : bblur_pkg::CH_W'(0),
                    pix.blue_in, pix.green_in, pix.red_in};

    always_ff @(posedge clk)
    begin
        if (a_move)
            line_mem[a_addr_reg] <= {line_rd_reg[PW-1:0], a_px_reg};
        if (pix_acc)
            line_rd_reg <= line_mem[col_cnt_reg];
    end

    // ------------------------------------------------------------------
    // Stage A
    // ------------------------------------------------------------------
    logic [CW+OW-1:0] col_wide;
    logic [RW-1:0]    a_row_reg;
    logic [OW-1:0]    a_col_reg;
    logic             a_blur_reg;
    logic             a_border_reg;

    assign col_wide = {{OW{1'b0}}, col_cnt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (pix_acc)
            a_valid_reg <= 1'b1;
        else if (adv)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            a_px_reg     <= px_in;
            a_addr_reg   <= col_cnt_reg;
            a_row_reg    <= row_cnt_reg;
            a_col_reg    <= col_wide[OW-1:0];
            a_blur_reg   <= blur_now;
            a_border_reg <= border_now;
        end
    end

    // Window: two previous columns of the three rows.
    //   [0],[1] older row   [2],[3] newer row   [4],[5] current row
    // Element [3] is the neighborhood center.
    logic [PW-1:0] win_reg [6];
    logic [PW-1:0] col3 [3];
    logic [SW-1:0] a_sum [3];

    always_comb
    begin
        col3[0] = line_rd_reg[2*PW-1:PW];
        col3[1] = line_rd_reg[PW-1:0];
        col3[2] = a_px_reg;
        for (int k = 0; k < 3; k++)
        begin
            a_sum[k] = '0;
            for (int j = 0; j < 3; j++)
            begin
                a_sum[k] = a_sum[k]
                         + SW'(win_reg[2*j][8*k +: 8])
                         + SW'(win_reg[2*j+1][8*k +: 8])
                         + SW'(col3[j][8*k +: 8]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 6; j++)
                win_reg[j] <= '0;
        end
        else if (a_move)
        begin
            for (int j = 0; j < 3; j++)
            begin
                win_reg[2*j]   <= win_reg[2*j+1];
                win_reg[2*j+1] <= col3[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B
    // ------------------------------------------------------------------
    logic [SW-1:0]             b_sum_reg [3];
    logic [bblur_pkg::CH_W-1:0] b_alpha_reg;
    logic [PW-1:0]             b_px_reg;
    logic [RW-1:0]             b_row_reg;
    logic [OW-1:0]             b_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg  <= 1'b0;
            b_blur_reg   <= 1'b0;
            b_border_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg  <= a_valid_reg;
            b_blur_reg   <= a_valid_reg && a_blur_reg;
            b_border_reg <= a_valid_reg && a_border_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            for (int k = 0; k < 3; k++)
                b_sum_reg[k] <= a_sum[k];
            b_alpha_reg <= win_reg[3][PW-1 -: bblur_pkg::CH_W];
            b_px_reg    <= a_px_reg;
            b_row_reg   <= a_row_reg;
            b_col_reg   <= a_col_reg;
        end
    end

    // Mean by reciprocal multiply; exact floor for every 3x3 byte sum.
    logic [2*SW-1:0]            prod [3];
    logic [bblur_pkg::CH_W-1:0] mean [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod[k] = (2*SW)'(b_sum_reg[k]) * (2*SW)'(bblur_pkg::DIV9_MUL);
            mean[k] = prod[k][bblur_pkg::DIV9_SHIFT +: bblur_pkg::CH_W];
        end
    end

    // ------------------------------------------------------------------
    // Result queue: head at entry 0, shifts on pop. Blurred pixel goes in
    // ahead of the border copy.
    // ------------------------------------------------------------------
    bblur_pkg::result_t q_reg  [bblur_pkg::QD];
    bblur_pkg::result_t q_next [bblur_pkg::QD];
    bblur_pkg::result_t blur_res;
    bblur_pkg::result_t copy_res;
    logic [QN-1:0]      base;
    logic [QN-1:0]      copy_pos;
    logic [QN-1:0]      cnt_next;

    always_comb
    begin
        blur_res.row    = b_row_reg - RW'(1);
        blur_res.column = b_col_reg - OW'(1);
        blur_res.red    = mean[0];
        blur_res.green  = mean[1];
        blur_res.blue   = mean[2];
        blur_res.alpha  = b_alpha_reg;
        blur_res.last   = !b_border_reg;

        copy_res.row    = b_row_reg;
        copy_res.column = b_col_reg;
        copy_res.red    = b_px_reg[7:0];
        copy_res.green  = b_px_reg[15:8];
        copy_res.blue   = b_px_reg[23:16];
        copy_res.alpha  = b_px_reg[31:24];
        copy_res.last   = 1'b1;

        for (int i = 0; i < bblur_pkg::QD; i++)
        begin
            if (pop && (i < bblur_pkg::QD - 1))
                q_next[i] = q_reg[i+1];
            else
                q_next[i] = q_reg[i];
        end

        base     = cnt_reg - QN'(pop);
        copy_pos = base + QN'(b_blur_reg);
        if (b_push && b_blur_reg)
            q_next[base[bblur_pkg::QIDX_W-1:0]] = blur_res;
        if (b_push && b_border_reg)
            q_next[copy_pos[bblur_pkg::QIDX_W-1:0]] = copy_res;

        cnt_next = base + (b_push ? QN'(b_nres) : QN'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign res.out_row     = q_reg[0].row;
    assign res.out_column  = q_reg[0].column;
    assign res.red_out     = q_reg[0].red;
    assign res.green_out   = q_reg[0].green;
    assign res.blue_out    = q_reg[0].blue;
    assign res.alpha_out   = q_reg[0].alpha;
    assign res.last_of_run = q_reg[0].last;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QN'(bblur_pkg::QD))
        else $error("result queue count out of range");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        b_push |-> ((QN+1)'(cnt_reg) + (QN+1)'(b_nres) <= (QN+1)'(bblur_pkg::QD)))
        else $error("stage B pushed into a full result queue");

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        c_ext < w_eff)
        else $error("column counter ran past the image width");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_en |=> (col_cnt_reg == '0 && row_cnt_reg == '0))
        else $error("config write did not restart the frame");
`endif

endmodule
